/* hw/rtl/seesch_pkg.sv */
// shared types and constants for the smoothed encoder event scheduler
`timescale 1ns / 1ps
package seesch_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;

	// register indexes and reset values
	localparam logic [1:0] CFG_CLICK_EVENTS = 2'd0;
	localparam logic [1:0] CFG_STEP_TIME_US = 2'd1;
	localparam logic [5:0]  EPC_RESET  = 6'd12;
	localparam logic [15:0] STEP_RESET = 16'd1000;
	localparam logic [5:0]  F_MAX      = 6'd32;

	// action codes
	localparam logic [1:0] ACT_SAMPLE  = 2'd0;
	localparam logic [1:0] ACT_TICK    = 2'd1;
	localparam logic [1:0] ACT_PRELOAD = 2'd2;
	localparam logic [1:0] ACT_UNUSED  = 2'd3;

	// direction codes of last_dir
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_CW   = 2'd1;
	localparam logic [1:0] DIR_CCW  = 2'd2;

	// events per sample saturate here
	localparam logic [7:0] EVENT_MAX = 8'd255;

	// divider: quotient bits, numerator and divisor widths
	localparam int QUOT_W = 22;
	localparam int NUM_W  = 42;
	localparam int DEN_W  = 21;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] position;
		logic [31:0]        now_us;
	} in_word_t;

	typedef struct packed {
		logic               event_valid;
		logic               direction;
		logic [4:0]         click_step;
		logic signed [31:0] count_value;
		logic [6:0]         queue_level;
	} out_word_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [15:0] value;
	} cfg_word_t;

	typedef struct packed {
		logic        dir;
		logic [4:0]  step;
		logic [31:0] due;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SAMPLE,
		ST_DEN_A,
		ST_DEN_B,
		ST_LOOP,
		ST_K_SQ,
		ST_K_CUBE,
		ST_K_F,
		ST_POLY,
		ST_TERM,
		ST_NUM,
		ST_DIV,
		ST_PUSH,
		ST_TICK,
		ST_RESP
	} state_t;

endpackage

/* hw/rtl/seesch_chan_if.sv */
// valid/ready channel carrying one word of a given payload type
`timescale 1ns / 1ps
interface seesch_chan_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/smoothed_encoder_event_scheduler.sv */
// top level of the smoothed encoder event scheduler
`timescale 1ns / 1ps
// Takes one word at a time and returns exactly one result word for it. For a count
// sample, each event's eased delay goes through one shared 32x16 multiplier five
// times and then a 22-step restoring divider. Events beyond a full queue are
// dropped without being computed. The block is not ready while it works on a
// word; a finished result waits in an output register while the next word is
// taken. Registers may be written at any time the block is idle; a factor of 0
// acts as 1 and above 32 acts as 32.
module smoothed_encoder_event_scheduler import seesch_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	seesch_chan_if.sink   items,
	seesch_chan_if.source results,
	seesch_chan_if.sink   regs
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int DIV_CNT_W = $clog2(QUOT_W);

	state_t state_q, state_d;

	// configuration
	logic [5:0]  epc_q;
	logic [15:0] step_q;

	// item and queue state
	logic [1:0]        act_q;
	logic [31:0]       pos_q;
	logic [31:0]       now_q;
	logic [31:0]       d_q;
	logic [31:0]       cur_q;
	logic [31:0]       prev_q;
	logic [1:0]        last_dir_q;
	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  tail_q;
	logic [CNT_W-1:0]  pending_q;

	// released event
	logic       evv_q;
	logic       evdir_q;
	logic [4:0] evstep_q;

	// per sample loop
	logic       dir_bit_q;
	logic [7:0] rem_q;
	logic [4:0] s_q;
	logic [5:0] f_q;
	logic [10:0] ff_q;
	logic [DEN_W-1:0] den_q;
	logic [10:0] kk_q;
	logic [15:0] k3_q;
	logic [10:0] kf_q;
	logic [14:0] poly_q;
	logic [25:0] t_q;
	logic [DEN_W-1:0] div_r_q;
	logic [QUOT_W-1:0] div_n_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	// output register
	logic      ov_q;
	out_word_t out_q;

	// shared multiplier
	logic [31:0] mul_a;
	logic [15:0] mul_b;
	logic [47:0] mul_p;
	assign mul_p = 48'(mul_a) * 48'(mul_b);

	// queue store
	logic   ram_we;
	entry_t wr_entry;
	entry_t rd_entry;
	logic [37:0] rd_raw;

	seesch_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (wr_entry),
		.raddr (head_q),
		.rdata (rd_raw)
	);
	assign rd_entry = entry_t'(rd_raw);

	// derived values
	logic [5:0]  f_clamp;
	logic [5:0]  k;
	logic        full;
	logic        neg;
	logic [31:0] mag;
	logic [13:0] n_prod;
	logic [7:0]  n_events;
	logic [1:0]  new_dir;
	logic [16:0] poly_sum;
	logic [QUOT_W-1:0] div_t;
	logic        div_ge;
	logic        divider_done;
	logic        out_free;
	logic        tick_pop;

	always_comb begin
		if (epc_q == 6'd0) begin
			f_clamp = 6'd1;
		end else if (epc_q > F_MAX) begin
			f_clamp = F_MAX;
		end else begin
			f_clamp = epc_q;
		end
	end

	assign k        = {1'b0, s_q} + 6'd1;
	assign full     = (pending_q == CNT_W'(QUEUE_DEPTH));
	assign neg      = d_q[31];
	assign mag      = neg ? (~d_q + 32'd1) : d_q;
	assign n_prod   = mag[7:0] * {2'b0, f_clamp};
	assign n_events = (mag > 32'd255 || n_prod > 14'd255) ? EVENT_MAX : n_prod[7:0];
	assign new_dir  = neg ? DIR_CCW : DIR_CW;

	// smootherstep polynomial 6k^2 - 15kF + 10F^2, always positive
	assign poly_sum = 17'({kk_q, 2'b0}) + 17'({kk_q, 1'b0}) + 17'({ff_q, 3'b0})
		+ 17'({ff_q, 1'b0}) - (17'({kf_q, 4'b0}) - 17'(kf_q));

	// restoring divider step
	assign div_t        = {div_r_q, div_n_q[QUOT_W-1]};
	assign div_ge       = (div_t >= QUOT_W'(den_q));
	assign divider_done = (div_cnt_q == DIV_CNT_W'(QUOT_W - 1));

	assign out_free = !ov_q || results.ready;
	assign tick_pop = (pending_q != '0) && (rd_entry.due <= now_q);

	assign wr_entry.dir  = dir_bit_q;
	assign wr_entry.step = s_q;
	assign wr_entry.due  = now_q + 32'(div_n_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (items.valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (act_q)
					ACT_SAMPLE: state_d = ST_SAMPLE;
					ACT_TICK:   state_d = ST_TICK;
					default:    state_d = ST_RESP;
				endcase
			end
			ST_SAMPLE: begin
				state_d = (d_q == 32'd0) ? ST_RESP : ST_DEN_A;
			end
			ST_DEN_A:  state_d = ST_DEN_B;
			ST_DEN_B:  state_d = ST_LOOP;
			ST_LOOP: begin
				state_d = (rem_q == 8'd0 || full) ? ST_RESP : ST_K_SQ;
			end
			ST_K_SQ:   state_d = ST_K_CUBE;
			ST_K_CUBE: state_d = ST_K_F;
			ST_K_F:    state_d = ST_POLY;
			ST_POLY:   state_d = ST_TERM;
			ST_TERM:   state_d = ST_NUM;
			ST_NUM:    state_d = ST_DIV;
			ST_DIV: begin
				if (divider_done) state_d = ST_PUSH;
			end
			ST_PUSH:   state_d = ST_LOOP;
			ST_TICK:   state_d = ST_RESP;
			ST_RESP: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// handshake, multiplier operands and store write
	always_comb begin
		items.ready = (state_q == ST_IDLE);
		regs.ready  = 1'b1;
		ram_we      = (state_q == ST_PUSH);
		mul_a       = 32'd0;
		mul_b       = 16'd0;
		case (state_q)
			ST_DEN_A: begin
				mul_a = 32'(f_q);
				mul_b = 16'(f_q);
			end
			ST_DEN_B: begin
				mul_a = 32'(ff_q);
				mul_b = 16'(ff_q);
			end
			ST_K_SQ: begin
				mul_a = 32'(k);
				mul_b = 16'(k);
			end
			ST_K_CUBE: begin
				mul_a = 32'(kk_q);
				mul_b = 16'(k);
			end
			ST_K_F: begin
				mul_a = 32'(k);
				mul_b = 16'(f_q);
			end
			ST_TERM: begin
				mul_a = 32'(k3_q);
				mul_b = 16'(poly_q);
			end
			ST_NUM: begin
				mul_a = 32'(t_q);
				mul_b = step_q;
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 16'd0;
			end
		endcase
	end

	assign results.valid = ov_q;
	assign results.data  = out_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epc_q  <= EPC_RESET;
			step_q <= STEP_RESET;
		end else if (regs.valid) begin
			case (regs.data.index)
				CFG_CLICK_EVENTS: epc_q <= regs.data.value[5:0];
				CFG_STEP_TIME_US: step_q <= regs.data.value;
				default: ;
			endcase
		end
	end

	// counts, queue pointers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= '0;
			prev_q     <= '0;
			last_dir_q <= DIR_NONE;
			head_q     <= '0;
			tail_q     <= '0;
			pending_q  <= '0;
			ov_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_DISPATCH: begin
					if (act_q == ACT_SAMPLE || act_q == ACT_PRELOAD) cur_q <= pos_q;
					if (act_q == ACT_PRELOAD) prev_q <= pos_q;
				end
				ST_SAMPLE: begin
					if (d_q != 32'd0) begin
						prev_q <= pos_q;
						if (new_dir != last_dir_q) begin
							head_q     <= '0;
							tail_q     <= '0;
							pending_q  <= '0;
							last_dir_q <= new_dir;
						end
					end
				end
				ST_PUSH: begin
					tail_q    <= (tail_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
					pending_q <= pending_q + 1'b1;
				end
				ST_TICK: begin
					if (tick_pop) begin
						head_q    <= (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
						pending_q <= pending_q - 1'b1;
					end
				end
				default: ;
			endcase
			if (state_q == ST_RESP && out_free) begin
				ov_q <= 1'b1;
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				act_q    <= items.data.action;
				pos_q    <= items.data.position;
				now_q    <= items.data.now_us;
				evv_q    <= 1'b0;
				evdir_q  <= 1'b0;
				evstep_q <= 5'd0;
			end
			ST_DISPATCH: begin
				d_q <= pos_q - prev_q;
			end
			ST_SAMPLE: begin
				dir_bit_q <= neg;
				rem_q     <= n_events;
				s_q       <= 5'd0;
				f_q       <= f_clamp;
			end
			ST_DEN_A:  ff_q  <= mul_p[10:0];
			ST_DEN_B:  den_q <= mul_p[DEN_W-1:0];
			ST_K_SQ:   kk_q  <= mul_p[10:0];
			ST_K_CUBE: k3_q  <= mul_p[15:0];
			ST_K_F:    kf_q  <= mul_p[10:0];
			ST_POLY:   poly_q <= poly_sum[14:0];
			ST_TERM:   t_q   <= mul_p[25:0];
			ST_NUM: begin
				// high part is below the divisor since the quotient fits QUOT_W bits
				div_r_q   <= mul_p[QUOT_W +: DEN_W];
				div_n_q   <= mul_p[QUOT_W-1:0];
				div_cnt_q <= '0;
			end
			ST_DIV: begin
				div_r_q   <= div_ge ? DEN_W'(div_t - QUOT_W'(den_q)) : DEN_W'(div_t);
				div_n_q   <= {div_n_q[QUOT_W-2:0], div_ge};
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			ST_PUSH: begin
				rem_q <= rem_q - 8'd1;
				s_q   <= (k >= f_q) ? 5'd0 : k[4:0];
			end
			ST_TICK: begin
				if (tick_pop) begin
					evv_q    <= 1'b1;
					evdir_q  <= rd_entry.dir;
					evstep_q <= rd_entry.step;
				end
			end
			default: ;
		endcase
		if (state_q == ST_RESP && out_free) begin
			out_q.event_valid <= evv_q;
			out_q.direction   <= evdir_q;
			out_q.click_step  <= evstep_q;
			out_q.count_value <= cur_q;
			out_q.queue_level <= 7'(pending_q);
		end
	end

endmodule

/* hw/rtl/seesch_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module seesch_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* bench/smoothed_encoder_event_scheduler_tb.sv */
// testbench for the smoothed encoder event scheduler: directed and random words
`timescale 1ns / 1ps
module smoothed_encoder_event_scheduler_tb;
	import seesch_pkg::*;

	logic clk;
	logic arst_n;

	seesch_chan_if #(.payload_t(in_word_t))  items ();
	seesch_chan_if #(.payload_t(out_word_t)) results ();
	seesch_chan_if #(.payload_t(cfg_word_t)) regs ();

	smoothed_encoder_event_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items.sink),
		.results(results.source),
		.regs(regs.sink)
	);

	localparam int DEPTH = QUEUE_DEPTH_DEF;

	// scheduler state mirrored in the bench
	entry_t      sched_q[$];
	logic [31:0] cur_count;
	logic [31:0] prev_count;
	logic [1:0]  cur_dir;
	logic [5:0]  epc_reg;
	logic [15:0] step_reg;

	out_word_t   expected_q[$];
	int          mismatches;
	bit          hold_off;
	int          hold_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// short gaps mostly, long ones now and then
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// floor of step * F * smootherstep(k / F)
	function automatic logic [31:0] eased_due(logic [15:0] st, int unsigned f, int unsigned s);
		longint unsigned k;
		longint unsigned ff;
		longint unsigned poly;
		longint unsigned num;
		k = s + 1;
		ff = f;
		poly = 6 * k * k + 10 * ff * ff - 15 * k * ff;
		num = longint'(st) * k * k * k * poly;
		return 32'(num / (ff * ff * ff * ff));
	endfunction

	// work out the result of one input word
	function automatic out_word_t schedule_word(in_word_t w);
		out_word_t   r;
		logic [31:0] d;
		logic [31:0] mag;
		logic [1:0]  dir;
		int unsigned f;
		int unsigned n;
		entry_t      e;
		r = '0;
		case (w.action)
			ACT_SAMPLE: begin
				d = w.position - prev_count;
				cur_count = w.position;
				if (d != 0) begin
					dir = d[31] ? DIR_CCW : DIR_CW;
					mag = d[31] ? -d : d;
					f = epc_reg;
					if (f == 0) f = 1;
					if (f > F_MAX) f = F_MAX;
					if (dir != cur_dir) begin
						sched_q.delete();
						cur_dir = dir;
					end
					n = (mag > EVENT_MAX) ? EVENT_MAX : mag * f;
					if (n > EVENT_MAX) n = EVENT_MAX;
					for (int i = 0; i < n; i++) begin
						if (sched_q.size() < DEPTH) begin
							e.dir = (dir == DIR_CCW);
							e.step = 5'(i % f);
							e.due = w.now_us + eased_due(step_reg, f, i % f);
							sched_q.push_back(e);
						end
					end
					prev_count = w.position;
				end
			end
			ACT_TICK: begin
				if (sched_q.size() > 0 && sched_q[0].due <= w.now_us) begin
					e = sched_q.pop_front();
					r.event_valid = 1'b1;
					r.direction = e.dir;
					r.click_step = e.step;
				end
			end
			ACT_PRELOAD: begin
				cur_count = w.position;
				prev_count = w.position;
			end
			default: ;
		endcase
		r.count_value = cur_count;
		r.queue_level = 7'(sched_q.size());
		return r;
	endfunction

	task automatic idle_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	// offer one word and wait for it to be taken
	task automatic send_word(logic [1:0] act, logic [31:0] pos, logic [31:0] now);
		in_word_t w;
		// valid drops between words
		idle_cycles(1 + gap_len());
		w.action = act;
		w.position = pos;
		w.now_us = now;
		items.valid <= 1'b1;
		items.data <= w;
		@(posedge clk);
		while (!items.ready) @(posedge clk);
		expected_q.push_back(schedule_word(w));
		items.valid <= 1'b0;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_word_t c;
		idle_cycles(1);
		c.index = idx;
		c.value = val;
		regs.valid <= 1'b1;
		regs.data <= c;
		@(posedge clk);
		while (!regs.ready) @(posedge clk);
		regs.valid <= 1'b0;
		if (idx == CFG_CLICK_EVENTS) epc_reg = val[5:0];
		else if (idx == CFG_STEP_TIME_US) step_reg = val;
	endtask

	// let the block drain before a register write
	task automatic drain();
		while (expected_q.size() != 0) @(posedge clk);
		idle_cycles(40);
	endtask

	// accept results with random stalls
	initial begin
		results.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				results.ready <= 1'b0;
				hold_cycles++;
			end else if ($urandom_range(0, 199) == 0) begin
				results.ready <= 1'b0;
				idle_cycles($urandom_range(10, 50));
			end else begin
				results.ready <= ($urandom_range(0, 99) < 70);
			end
		end
	end

	// compare each result with the oldest expectation
	initial begin
		out_word_t exp_w;
		forever begin
			@(posedge clk);
			if (arst_n && results.valid && results.ready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %p", results.data);
				end else begin
					exp_w = expected_q.pop_front();
					if (results.data !== exp_w) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected %p actual %p",
								exp_w, results.data);
					end
				end
			end
		end
	end

	// extremes of every field, each action, direction reversal, full queue
	task automatic test_directed();
		send_word(ACT_TICK, 32'h0, 32'h0);
		send_word(ACT_SAMPLE, 32'd1, 32'd100);
		send_word(ACT_TICK, 32'hFFFF_FFFF, 32'd100);
		send_word(ACT_TICK, 32'h0, 32'hFFFF_FFFF);
		send_word(ACT_SAMPLE, 32'd0, 32'hFFFF_FF00);
		send_word(ACT_TICK, 32'h0, 32'hFFFF_FFFF);
		send_word(ACT_TICK, 32'h0, 32'h0);
		send_word(ACT_UNUSED, 32'h1234_5678, 32'h0);
		send_word(ACT_PRELOAD, 32'h7FFF_FFFF, 32'h0);
		send_word(ACT_SAMPLE, 32'h8000_0000, 32'h0);
		send_word(ACT_SAMPLE, 32'h8000_0000, 32'h0);
		send_word(ACT_PRELOAD, 32'h8000_0000, 32'h0);
		send_word(ACT_SAMPLE, 32'h8000_0006, 32'hAAAA_5555);
		for (int i = 0; i < 6; i++) send_word(ACT_TICK, 32'h5555_AAAA, 32'hFFFF_FFFF);
		send_word(ACT_SAMPLE, 32'h8000_0005, 32'd7);
		send_word(ACT_TICK, 32'h0, 32'd7);
		send_word(ACT_PRELOAD, 32'h0, 32'h0);
	endtask

	// factor extremes and odd values, step time extremes
	task automatic test_config_sweep();
		logic [15:0] epcs[6] = '{16'd0, 16'd1, 16'd32, 16'd63, 16'd33, 16'd7};
		logic [15:0] steps[6] = '{16'd1, 16'd65535, 16'd0, 16'd1000, 16'd3, 16'd40000};
		for (int c = 0; c < 6; c++) begin
			drain();
			write_reg(CFG_CLICK_EVENTS, epcs[c]);
			write_reg(CFG_STEP_TIME_US, steps[c]);
			send_word(ACT_SAMPLE, cur_count + 2, 32'd0);
			for (int i = 0; i < 4; i++) send_word(ACT_TICK, $urandom, $urandom);
			send_word(ACT_SAMPLE, cur_count - 1, 32'd10);
			send_word(ACT_TICK, 32'h0, 32'hFFFF_FFFF);
		end
	endtask

	// realistic rotation: small moves and ticks on a rising clock of time
	task automatic test_random(int total);
		logic [31:0] clock_us;
		int r;
		clock_us = $urandom;
		for (int i = 0; i < total; i++) begin
			if (i % 400 == 399) begin
				drain();
				write_reg(CFG_CLICK_EVENTS, 16'($urandom_range(1, 6)));
				write_reg(CFG_STEP_TIME_US, 16'($urandom_range(1, 300)));
			end
			r = $urandom_range(0, 99);
			if (r < 20)
				send_word(ACT_SAMPLE, cur_count + $urandom_range(0, 4) - 2, clock_us);
			else if (r < 80) begin
				clock_us += $urandom_range(0, 400);
				send_word(ACT_TICK, $urandom, clock_us);
			end else if (r < 85)
				send_word(ACT_PRELOAD, $urandom, $urandom);
			else if (r < 88)
				send_word(ACT_UNUSED, $urandom, $urandom);
			else if (r < 92)
				send_word(ACT_SAMPLE, cur_count + 32'($urandom_range(3, 300)) *
					($urandom_range(0, 1) ? 1 : -1), clock_us);
			else
				send_word(ACT_TICK, $urandom, $urandom);
		end
	endtask

	// receiver holds off long while words keep coming
	task automatic test_backpressure();
		drain();
		hold_cycles = 0;
		hold_off = 1'b1;
		fork
			begin
				while (hold_cycles < 300) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 12; i++) send_word(ACT_PRELOAD, $urandom, $urandom);
		join
	endtask

	initial begin
		mismatches = 0;
		hold_off = 1'b0;
		hold_cycles = 0;
		epc_reg = EPC_RESET;
		step_reg = STEP_RESET;
		cur_count = '0;
		prev_count = '0;
		cur_dir = DIR_NONE;
		items.valid = 1'b0;
		items.data = '0;
		regs.valid = 1'b0;
		regs.data = '0;
		arst_n = 1'b0;
		idle_cycles(3);
		arst_n <= 1'b1;
		idle_cycles(2);
		test_directed();
		test_config_sweep();
		test_backpressure();
		test_random(1500);
		while (expected_q.size() != 0) @(posedge clk);
		idle_cycles(50);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#40ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
